// ===== src/sktb_pkg.sv =====
// Shared types and constants of the sorted key table binary search core.
package sktb_pkg;

    localparam int ENTRIES      = 256;
    localparam int KEY_WORDS    = 8;
    localparam int WORD_BITS    = 16;
    localparam int ENTRY_BITS   = $clog2(ENTRIES);
    localparam int WIDX_BITS    = $clog2(KEY_WORDS);
    localparam int KW_CNT_BITS  = $clog2(KEY_WORDS + 1);
    localparam int POS_BITS     = ENTRY_BITS + 2;
    localparam int CFG_BITS     = 4;
    localparam int CMD_BITS     = 2;
    localparam int PROBE_BITS   = 8;
    localparam int ORD_BITS     = 2;
    localparam int S_TDATA_BITS = 48;
    localparam int M_TDATA_BITS = 16;

    typedef logic [WORD_BITS-1:0]                word_t;
    typedef logic [KEY_WORDS-1:0][WORD_BITS-1:0] row_t;
    typedef logic signed [POS_BITS-1:0]          pos_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WR_TABLE = 2'd0,
        CMD_WR_QUERY = 2'd1,
        CMD_SEARCH   = 2'd2
    } cmd_t;

    typedef enum logic [ORD_BITS-1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } ord_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ENTRY_BITS-1:0] wr_entry;
        logic [WIDX_BITS-1:0]  wr_word;
        word_t                 wr_data;
        logic                  rd_en;
        logic [ENTRY_BITS-1:0] rd_entry;
    } ram_req_t;

    typedef struct packed {
        logic                 en;
        logic [WIDX_BITS-1:0] word;
        word_t                data;
    } qry_wr_t;

endpackage

// ===== src/sorted_key_table_binary_search_core.sv =====
// Top level of the sorted key table binary search core.
//
// The s_ channel takes commands: s_tuser selects a table word write, a query
// word write or a search. Writes complete in the transaction cycle and
// produce no result. A search runs a binary search over the given index
// range of the table and returns one result on the m_ channel: the order of
// the query against the last probed entry and that entry's index.
// Each probe reads one row through the single memory read port and then
// compares it with the query key. The next command is taken in the cycle
// after the result is loaded. The result register lets the next command in
// while a result waits; if a second result is ready before the first is
// taken, the search holds until the receiver accepts. The cfg channel
// writes the key word count; it is always ready. The user must write it
// only while no search is in flight; the block itself does not enforce it.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empties
// the result register and sets the key word count to one. Table and query
// contents are undefined until written.
module sorted_key_table_binary_search_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: entry_index[7:0], word_index[2:0], word_value[15:0],
    // range_start[7:0], range_end[7:0], zero padding.
    input  logic [sktb_pkg::S_TDATA_BITS-1:0] s_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [sktb_pkg::CMD_BITS-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: order_result[1:0], probe_index[7:0], zero padding.
    output logic [sktb_pkg::M_TDATA_BITS-1:0] m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sktb_pkg::CFG_BITS-1:0]     cfg_data
);
    import sktb_pkg::*;

    ram_req_t ram_req;
    qry_wr_t  qry_wr;
    row_t     rd_row;
    logic     probe_oob;
    ord_t     cmp_ord;

    assign cfg_ready = 1'b1;

    sktb_key_ram u_key_ram (
        .aclk   (aclk),
        .req    (ram_req),
        .rd_row (rd_row)
    );

    sktb_key_cmp u_key_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .qry_wr    (qry_wr),
        .rd_row    (rd_row),
        .probe_oob (probe_oob),
        .ord       (cmp_ord)
    );

    sktb_search_ctrl u_search_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ram_req   (ram_req),
        .qry_wr    (qry_wr),
        .probe_oob (probe_oob),
        .cmp_ord   (cmp_ord)
    );

endmodule

// ===== src/sktb_key_ram.sv =====
// Key table memory: one row per entry, word-lane writes, registered row reads.
module sktb_key_ram (
    input  logic              aclk,
    input  sktb_pkg::ram_req_t req,
    output sktb_pkg::row_t     rd_row
);
    import sktb_pkg::*;

    row_t mem [ENTRIES];
    row_t rd_row_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_entry][req.wr_word] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_row_reg <= mem[req.rd_entry];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

// ===== src/sktb_key_cmp.sv =====
// Query key register file, key word count register and lexicographic comparator.
module sktb_key_cmp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [sktb_pkg::CFG_BITS-1:0]   cfg_data,
    input  sktb_pkg::qry_wr_t               qry_wr,
    input  sktb_pkg::row_t                  rd_row,
    input  logic                            probe_oob,
    output sktb_pkg::ord_t                  ord
);
    import sktb_pkg::*;

    word_t                 query_reg [KEY_WORDS];
    logic [CFG_BITS-1:0]   kw_reg;
    logic [CFG_BITS-1:0]   kw_next;
    logic [KW_CNT_BITS-1:0] n_words;
    row_t                  entry_row;

    always_comb begin
        kw_next = kw_reg;
        if (cfg_valid) begin
            kw_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_reg <= CFG_BITS'(1);
        end else begin
            kw_reg <= kw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (qry_wr.en) begin
            query_reg[qry_wr.word] <= qry_wr.data;
        end
    end

    assign n_words = (32'(kw_reg) > 32'(KEY_WORDS)) ? KW_CNT_BITS'(KEY_WORDS)
                                                   : KW_CNT_BITS'(kw_reg);
    assign entry_row = probe_oob ? '0 : rd_row;

    // The lowest differing word in use decides the order.
    always_comb begin
        ord = ORD_EQUAL;
        for (int w = KEY_WORDS - 1; w >= 0; w--) begin
            if (KW_CNT_BITS'(w) < n_words && query_reg[w] != entry_row[w]) begin
                ord = (query_reg[w] > entry_row[w]) ? ORD_GREATER : ORD_LESS;
            end
        end
    end

endmodule

// ===== src/sktb_search_ctrl.sv =====
// Command sequencer: table and query writes, binary search probes and result register.
module sktb_search_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sktb_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic [sktb_pkg::CMD_BITS-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sktb_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output sktb_pkg::ram_req_t                  ram_req,
    output sktb_pkg::qry_wr_t                   qry_wr,
    output logic                                probe_oob,
    input  sktb_pkg::ord_t                      cmp_ord
);
    import sktb_pkg::*;

    ctrl_state_t state_reg, state_next;
    pos_t        first_reg, first_next;
    pos_t        last_reg, last_next;
    pos_t        pivot_reg, pivot_next;
    logic        oob_reg, oob_next;
    ord_t        res_ord_reg, res_ord_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    cmd_t                  cmd;
    logic [7:0]            entry_index;
    logic [2:0]            word_index;
    logic [15:0]           word_value;
    logic [7:0]            range_start;
    logic [7:0]            range_end;
    pos_t                  pivot_mid;
    logic                  slot_free;
    logic                  done;
    logic                  entry_ok;
    logic                  word_ok;

    function automatic pos_t midpoint(pos_t first, pos_t last);
        pos_t d;
        begin
            d = last - first;
            if (d < 0) begin
                midpoint = first;
            end else begin
                midpoint = first + (d >>> 1);
            end
        end
    endfunction

    assign cmd         = cmd_t'(s_tuser);
    assign entry_index = s_tdata[7:0];
    assign word_index  = s_tdata[10:8];
    assign word_value  = s_tdata[26:11];
    assign range_start = s_tdata[34:27];
    assign range_end   = s_tdata[42:35];

    assign entry_ok  = (32'(entry_index) < 32'(ENTRIES));
    assign word_ok   = (32'(word_index) < 32'(KEY_WORDS));
    assign pivot_mid = midpoint(first_reg, last_reg);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign done      = (cmp_ord == ORD_EQUAL) || (first_reg >= last_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && cmd == CMD_SEARCH) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (!done) begin
                    state_next = ST_READ;
                end else if (slot_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        ram_req       = '0;
        qry_wr        = '0;
        first_next    = first_reg;
        last_next     = last_reg;
        pivot_next    = pivot_reg;
        oob_next      = oob_reg;
        res_ord_next  = res_ord_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (cmd)
                        CMD_WR_TABLE: begin
                            ram_req.wr_en    = entry_ok && word_ok;
                            ram_req.wr_entry = ENTRY_BITS'(entry_index);
                            ram_req.wr_word  = WIDX_BITS'(word_index);
                            ram_req.wr_data  = WORD_BITS'(word_value);
                        end
                        CMD_WR_QUERY: begin
                            qry_wr.en   = word_ok;
                            qry_wr.word = WIDX_BITS'(word_index);
                            qry_wr.data = WORD_BITS'(word_value);
                        end
                        CMD_SEARCH: begin
                            first_next = pos_t'(range_start);
                            last_next  = pos_t'(range_end);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_req.rd_en    = 1'b1;
                ram_req.rd_entry = pivot_mid[ENTRY_BITS-1:0];
                pivot_next       = pivot_mid;
                oob_next         = (pivot_mid >= pos_t'(ENTRIES));
            end
            ST_CMP: begin
                if (done) begin
                    res_ord_next = cmp_ord;
                    if (slot_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = M_TDATA_BITS'({pivot_reg[PROBE_BITS-1:0], cmp_ord});
                    end
                end else if (cmp_ord == ORD_LESS) begin
                    last_next = pivot_reg - pos_t'(1);
                end else begin
                    first_next = pivot_reg + pos_t'(1);
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_BITS'({pivot_reg[PROBE_BITS-1:0], res_ord_reg});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg   <= first_next;
        last_reg    <= last_next;
        pivot_reg   <= pivot_next;
        oob_reg     <= oob_next;
        res_ord_reg <= res_ord_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign probe_oob = oob_reg;

`ifndef SYNTHESIS
    a_search_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && cmd == CMD_SEARCH) |=> (state_reg == ST_READ))
        else $error("Accepted search did not start a probe read.");

    a_read_to_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_CMP))
        else $error("Probe read was not followed by a compare.");

    a_pivot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (pivot_reg >= first_reg && pivot_reg >= 0))
        else $error("Probe index fell below the search range.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_CMP || $past(state_reg) == ST_HOLD))
        else $error("Result appeared without a finished search.");
`endif

endmodule

// ===== test/sorted_key_table_binary_search_core_tb.sv =====
// Self-checking testbench for the sorted key table binary search core.
`timescale 1ns / 100ps

module sorted_key_table_binary_search_core_tb;
    import sktb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 24;
    localparam int ITEM_TARGET   = 600;
    localparam int SEARCH_TARGET = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [CMD_BITS-1:0] CMD_UNKNOWN = 2'd3;

    class search_scoreboard;
        typedef struct {
            logic [ORD_BITS-1:0]   ord;
            logic [PROBE_BITS-1:0] probe;
        } search_outcome_t;

        word_t                 rows [ENTRIES][KEY_WORDS];
        bit                    row_set [ENTRIES][KEY_WORDS];
        word_t                 query [KEY_WORDS];
        bit                    query_set [KEY_WORDS];
        logic [CFG_BITS-1:0]   kw_count;
        logic [PROBE_BITS-1:0] cursor;
        search_outcome_t       outcomes[$];
        bit                    hole_query;
        int                    hole_entry;
        int                    hole_word;
        int                    searches;
        int                    checked;
        int                    mismatches;

        function new();
            kw_count   = 1;
            cursor     = '0;
            searches   = 0;
            checked    = 0;
            mismatches = 0;
        endfunction

        function int words_used();
            return (kw_count > KEY_WORDS) ? KEY_WORDS : int'(kw_count);
        endfunction

        // Returns 0 when the comparison would read a word that was never written.
        function bit compare_row(input int idx, output int rel);
            int    w;
            word_t t;
            rel = 0;
            for (w = 0; w < words_used(); w++) begin
                t = '0;
                if (!query_set[w]) begin
                    hole_query = 1'b1;
                    hole_word  = w;
                    return 1'b0;
                end
                if (idx >= 0 && idx < ENTRIES) begin
                    if (!row_set[idx][w]) begin
                        hole_query = 1'b0;
                        hole_entry = idx;
                        hole_word  = w;
                        return 1'b0;
                    end
                    t = rows[idx][w];
                end
                if (query[w] > t) begin
                    rel = 1;
                    return 1'b1;
                end
                if (query[w] < t) begin
                    rel = -1;
                    return 1'b1;
                end
            end
            return 1'b1;
        endfunction

        function bit trace_search(input int lo_in, input int hi_in,
                                  output logic [ORD_BITS-1:0] ord,
                                  output logic [PROBE_BITS-1:0] probe);
            int lo;
            int hi;
            int pivot;
            int rel;
            lo    = lo_in;
            hi    = hi_in;
            pivot = (lo > hi) ? lo : lo + (hi - lo) / 2;
            while (1'b1) begin
                if (!compare_row(pivot, rel)) return 1'b0;
                if (rel == 0 || lo >= hi) break;
                if (rel < 0) hi = pivot - 1;
                else lo = pivot + 1;
                pivot = lo + (hi - lo) / 2;
            end
            ord   = 2'(rel + 1);
            probe = 8'(pivot);
            return 1'b1;
        endfunction

        function void note_input(input logic [CMD_BITS-1:0] cmd, input logic [7:0] entry,
                                 input logic [2:0] word, input word_t value,
                                 input logic [7:0] lo, input logic [7:0] hi);
            logic [ORD_BITS-1:0]   o;
            logic [PROBE_BITS-1:0] p;
            search_outcome_t       want;
            case (cmd)
                CMD_WR_TABLE: begin
                    rows[entry][word]    = value;
                    row_set[entry][word] = 1'b1;
                end
                CMD_WR_QUERY: begin
                    query[word]     = value;
                    query_set[word] = 1'b1;
                end
                CMD_SEARCH: begin
                    if (trace_search(int'(lo), int'(hi), o, p)) begin
                        cursor     = p;
                        want.ord   = o;
                        want.probe = p;
                        outcomes.push_back(want);
                        searches++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic [M_TDATA_BITS-1:0] beat);
            search_outcome_t want;
            if (outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: order %0d probe %0d",
                             beat[1:0], beat[9:2]);
                return;
            end
            want = outcomes.pop_front();
            checked++;
            if (beat[1:0] !== want.ord || beat[9:2] !== want.probe) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Search %0d mismatch: expected order %0d probe %0d, got order %0d probe %0d",
                             checked, want.ord, want.probe, beat[1:0], beat[9:2]);
            end
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic [CMD_BITS-1:0]     s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    search_scoreboard sb;
    bit               calm         = 1'b0;
    int               hold_request = 0;
    int               items_sent   = 0;
    int               configs_done = 0;
    int               cycle_count  = 0;

    sorted_key_table_binary_search_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : receiver
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_request > 0) begin
                held         = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
            end else if (held > 0) begin
                held--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(!calm && $urandom_range(99, 0) < 11);
            end
        end
    end

    task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [7:0] entry,
                             input logic [2:0] word, input word_t value,
                             input logic [7:0] lo, input logic [7:0] hi);
        if (!calm && $urandom_range(99, 0) < 11) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, hi, lo, value, word, entry};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, entry, word, value, lo, hi);
        if (cmd != CMD_UNKNOWN) items_sent++;
    endtask

    task automatic write_row_word(input int entry, input int word, input word_t value);
        send_item(CMD_WR_TABLE, 8'(entry), 3'(word), value,
                  8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    endtask

    task automatic write_query_word(input int word, input word_t value);
        send_item(CMD_WR_QUERY, 8'($urandom_range(255, 0)), 3'(word), value,
                  8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    endtask

    task automatic send_noise();
        send_item(CMD_UNKNOWN, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)),
                  16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)),
                  8'($urandom_range(255, 0)));
    endtask

    // Any word the search path would read before it is written gets a random value first.
    task automatic search_range(input int lo, input int hi);
        logic [ORD_BITS-1:0]   o;
        logic [PROBE_BITS-1:0] p;
        while (!sb.trace_search(lo, hi, o, p)) begin
            if (sb.hole_query) write_query_word(sb.hole_word, 16'($urandom_range(65535, 0)));
            else write_row_word(sb.hole_entry, sb.hole_word, 16'($urandom_range(65535, 0)));
        end
        send_item(CMD_SEARCH, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)),
                  16'($urandom_range(65535, 0)), 8'(lo), 8'(hi));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_words(input logic [CFG_BITS-1:0] count);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.kw_count = count;
        configs_done++;
    endtask

    task automatic load_region(input int base, input int count, input int width);
        int    e;
        int    w;
        word_t lead;
        lead = 16'($urandom_range(40000, 0));
        for (e = base; e < base + count; e++) begin
            lead = lead + 16'($urandom_range(3000, 0));
            for (w = 0; w < width; w++) begin
                if (w == 0) write_row_word(e, w, lead);
                else if ($urandom_range(1, 0)) write_row_word(e, w, 16'($urandom_range(3, 0)));
                else write_row_word(e, w, 16'($urandom_range(65535, 0)));
            end
        end
    endtask

    initial begin : stimulus
        int    round;
        int    base;
        int    count;
        int    width;
        int    pick;
        int    tries;
        int    sel;
        int    lo;
        int    hi;
        int    top;
        int    w;
        word_t v;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        write_row_word(0, 0, 16'h0000);
        write_row_word(255, 0, 16'hFFFF);
        write_row_word(127, 0, 16'h5555);
        write_row_word(128, 0, 16'hAAAA);
        write_query_word(0, 16'hAAAA);
        search_range(127, 128);
        search_range(255, 0);
        search_range(0, 0);
        search_range(0, 255);
        send_noise();
        write_query_word(7, 16'hFFFF);
        write_row_word(255, 7, 16'h0000);
        write_key_words(4'd8);
        search_range(255, 255);
        write_key_words(4'd15);
        search_range(254, 255);
        write_key_words(4'd0);
        search_range(3, 250);
        search_range(200, 100);
        write_key_words(4'd1);

        round = 0;
        while (items_sent < ITEM_TARGET || sb.searches < SEARCH_TARGET) begin
            round++;
            calm = (round >= 8 && round < 14);
            if (round % 5 == 0) begin
                sel = $urandom_range(99, 0);
                if (sel < 40) write_key_words(4'($urandom_range(3, 1)));
                else if (sel < 70) write_key_words(4'($urandom_range(8, 4)));
                else if (sel < 85) write_key_words(4'd8);
                else if (sel < 95) write_key_words(4'($urandom_range(15, 9)));
                else write_key_words(4'd0);
            end
            if (round == 20) wait_drained();

            width = (sb.words_used() == 0) ? 1 : sb.words_used();
            count = $urandom_range(8, 2);
            base  = $urandom_range(256 - count, 0);
            top   = base + count - 1;
            load_region(base, count, width);

            pick = $urandom_range(top, base);
            for (w = 0; w < width; w++) begin
                if ($urandom_range(99, 0) < 80) write_query_word(w, sb.rows[pick][w]);
                else write_query_word(w, 16'($urandom_range(65535, 0)));
            end

            if (round == 4) begin
                hold_request = HOLD_CYCLES;
                tries        = 14;
            end else begin
                tries = $urandom_range(8, 3);
            end

            repeat (tries) begin
                if ($urandom_range(99, 0) < 40) begin
                    w = $urandom_range(width - 1, 0);
                    if ($urandom_range(99, 0) < 30) v = 16'($urandom_range(65535, 0));
                    else if ($urandom_range(1, 0)) v = sb.query[w] + 1'b1;
                    else v = sb.query[w] - 1'b1;
                    write_query_word(w, v);
                end
                if ($urandom_range(99, 0) < 4) send_noise();
                sel = $urandom_range(99, 0);
                if (sel < 50) begin
                    lo = base;
                    hi = top;
                end else if (sel < 65) begin
                    lo = $urandom_range(top, base);
                    hi = $urandom_range(top, lo);
                end else if (sel < 75) begin
                    hi = $urandom_range(top - 1, base);
                    lo = $urandom_range(top, hi + 1);
                end else if (sel < 85) begin
                    lo = $urandom_range(top, base);
                    hi = lo;
                end else begin
                    lo = $urandom_range(255, 0);
                    hi = $urandom_range(255, 0);
                end
                search_range(lo, hi);
            end
        end
        calm = 1'b0;

        wait_drained();
        $display("Sent %0d transactions in %0d rounds; %0d search results checked.",
                 items_sent, round, sb.checked);
        $display("Key word count was rewritten %0d times, including zero and values above eight.",
                 configs_done);
        if (sb.mismatches == 0 && sb.outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
